// ===== rtl/core/cllt_pkg.sv =====
// Package for the cursor linked list table unit.
// Operation codes, controller command and datapath status types.
// No dependencies.
package cllt_pkg;

  localparam int FUNC_W     = 2;
  localparam int KEY_PORT_W = 32;

  localparam logic [FUNC_W-1:0] FN_INSERT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CONTAINS = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE   = 2'd2;

  typedef struct packed {
    logic load;
    logic rd_free;
    logic rd_head;
    logic walk_step;
    logic ins_write;
    logic ins_link;
    logic rm_capture;
    logic rm_fix;
    logic rm_free;
    logic set_hit;
    logic set_rej;
  } cllt_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              free_nil;
    logic              head_nil;
    logic              key_match;
    logic              next_nil;
  } cllt_status_t;

endpackage

// ===== rtl/core/cllt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module cllt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cllt_ctrl.sv =====
// Controller state machine for the cursor linked list table unit.
// Depends on cllt_pkg.
module cllt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  input  cllt_pkg::cllt_status_t sts,
  output cllt_pkg::cllt_cmd_t   cmd
);
  import cllt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_WALK     = 9'b000000100,
    S_INS      = 9'b000001000,
    S_INS_LINK = 9'b000010000,
    S_RM_FIX   = 9'b000100000,
    S_RM_FREE  = 9'b001000000,
    S_DONE     = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.func)
          FN_INSERT: begin
            if (sts.free_nil) begin
              cmd.set_rej = 1'b1;
              state_next  = S_DONE;
            end else begin
              cmd.rd_free = 1'b1;
              state_next  = S_INS;
            end
          end
          FN_CONTAINS, FN_REMOVE: begin
            if (sts.head_nil) begin
              state_next = S_DONE;
            end else begin
              cmd.rd_head = 1'b1;
              state_next  = S_WALK;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_WALK: begin
        priority if (sts.key_match) begin
          cmd.set_hit = 1'b1;
          if (sts.func == FN_REMOVE) begin
            cmd.rm_capture = 1'b1;
            state_next     = S_RM_FIX;
          end else begin
            state_next = S_DONE;
          end
        end else if (sts.next_nil) begin
          state_next = S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_INS: begin
        cmd.ins_write = 1'b1;
        state_next    = S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd.ins_link = 1'b1;
        state_next   = S_DONE;
      end
      S_RM_FIX: begin
        cmd.rm_fix = 1'b1;
        state_next = S_RM_FREE;
      end
      S_RM_FREE: begin
        cmd.rm_free = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ===== rtl/core/cllt_dp.sv =====
// Datapath for the cursor linked list table unit: slot RAMs, list and free
// heads, fill count, walk cursor and result flags. Depends on cllt_pkg, cllt_ram.
module cllt_dp #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [cllt_pkg::FUNC_W-1:0]         func,
  input  logic signed [cllt_pkg::KEY_PORT_W-1:0] key,
  input  cllt_pkg::cllt_cmd_t                 cmd,
  output cllt_pkg::cllt_status_t              sts,
  output logic                                hit,
  output logic                                rejected
);
  import cllt_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  logic [KEY_WIDTH+KEY_PORT_W-1:0] key_ext;
  logic [KEY_WIDTH-1:0] key_cut;
  logic [KEY_WIDTH-1:0] key_q;
  logic [FUNC_W-1:0]    func_q;

  logic [LW-1:0] list_head, free_head, fill, cur;
  logic [LW-1:0] c_q, n_q, p_q, rd_addr_q;

  // RAM ports
  logic                 re;
  logic [LW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] key_rdata;
  logic [LW-1:0]        next_rdata, prev_rdata, next_out;
  logic                 next_we, prev_we;
  logic [LW-1:0]        next_waddr, next_wdata, prev_waddr, prev_wdata;

  assign key_ext = {{KEY_WIDTH{1'b0}}, key};
  assign key_cut = key_ext[KEY_WIDTH-1:0];

  // slots at or above the fill count still hold their reset chain link
  assign next_out = (rd_addr_q >= fill) ? LW'(rd_addr_q + 1'b1) : next_rdata;

  assign re = cmd.rd_free | cmd.rd_head | cmd.walk_step;

  always_comb begin
    priority if (cmd.rd_free) begin
      rd_addr = free_head;
    end else if (cmd.rd_head) begin
      rd_addr = list_head;
    end else begin
      rd_addr = next_out;
    end
  end

  always_comb begin
    next_we    = 1'b0;
    next_waddr = free_head;
    next_wdata = list_head;
    priority if (cmd.ins_write) begin
      next_we = 1'b1;
    end else if (cmd.rm_fix) begin
      next_we    = (p_q < NIL);
      next_waddr = p_q;
      next_wdata = n_q;
    end else if (cmd.rm_free) begin
      next_we    = 1'b1;
      next_waddr = c_q;
      next_wdata = free_head;
    end else begin
      next_we = 1'b0;
    end
  end

  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = free_head;
    prev_wdata = NIL;
    priority if (cmd.ins_write) begin
      prev_we = 1'b1;
    end else if (cmd.ins_link) begin
      prev_we    = (list_head < NIL);
      prev_waddr = list_head;
      prev_wdata = c_q;
    end else if (cmd.rm_fix) begin
      prev_we    = (n_q < NIL);
      prev_waddr = n_q;
      prev_wdata = p_q;
    end else begin
      prev_we = 1'b0;
    end
  end

  cllt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (cmd.ins_write),
    .waddr (free_head[AW-1:0]),
    .wdata (key_q),
    .re    (re),
    .raddr (rd_addr[AW-1:0]),
    .rdata (key_rdata)
  );

  cllt_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr[AW-1:0]),
    .wdata (next_wdata),
    .re    (re),
    .raddr (rd_addr[AW-1:0]),
    .rdata (next_rdata)
  );

  cllt_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr[AW-1:0]),
    .wdata (prev_wdata),
    .re    (re),
    .raddr (rd_addr[AW-1:0]),
    .rdata (prev_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head <= NIL;
      free_head <= '0;
      fill      <= '0;
    end else begin
      if (cmd.ins_write) begin
        free_head <= next_out;
        if (free_head == fill) begin
          fill <= LW'(fill + 1'b1);
        end
      end
      if (cmd.ins_link) begin
        list_head <= c_q;
      end
      if (cmd.rm_fix && (c_q == list_head)) begin
        list_head <= n_q;
      end
      if (cmd.rm_free) begin
        free_head <= c_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func;
      key_q    <= key_cut;
      hit      <= 1'b0;
      rejected <= 1'b0;
    end
    if (cmd.set_hit) begin
      hit <= 1'b1;
    end
    if (cmd.set_rej) begin
      rejected <= 1'b1;
    end
    if (re) begin
      rd_addr_q <= rd_addr;
    end
    if (cmd.rd_head) begin
      cur <= list_head;
    end
    if (cmd.walk_step) begin
      cur <= next_out;
    end
    if (cmd.ins_write) begin
      c_q <= free_head;
    end
    if (cmd.rm_capture) begin
      c_q <= cur;
      n_q <= next_out;
      p_q <= prev_rdata;
    end
  end

  assign sts.func      = func_q;
  assign sts.free_nil  = (free_head >= NIL);
  assign sts.head_nil  = (list_head >= NIL);
  assign sts.key_match = (key_rdata == key_q);
  assign sts.next_nil  = (next_out >= NIL);

endmodule

// ===== rtl/core/cursor_linked_list_table_unit.sv =====
// Cursor linked list table unit: top level joining controller and datapath.
// Depends on cllt_pkg, cllt_ctrl, cllt_dp.
// Sequence: insert runs decode, slot write, link, done; rejected insert runs
// decode, done; contains or remove walk the list, remove then fixes and frees.
// Throughput: one request at a time; set by the list walk, one RAM read a cycle.
// Reset: synchronous; empties the list and chains every slot into the free list.
module cursor_linked_list_table_unit #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [cllt_pkg::FUNC_W-1:0]            func,
  input  logic signed [cllt_pkg::KEY_PORT_W-1:0] key,
  output logic                                   done,
  output logic                                   hit,
  output logic                                   rejected
);
  import cllt_pkg::*;

  cllt_cmd_t    cmd;
  cllt_status_t sts;

  cllt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .cmd   (cmd)
  );

  cllt_dp #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .func     (func),
    .key      (key),
    .cmd      (cmd),
    .sts      (sts),
    .hit      (hit),
    .rejected (rejected)
  );

endmodule

// ===== rtl/core/cllt_checker.sv =====
// Port level checker for the cursor linked list table unit, with its bind.
// Depends on cursor_linked_list_table_unit.
module cllt_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic hit,
  input logic rejected
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request not held busy");

  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("still busy after done");

  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    (busy && !done) |=> busy)
    else $error("busy dropped without done");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && rejected))
    else $error("hit and rejected together");

endmodule

bind cursor_linked_list_table_unit cllt_checker u_cllt_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .hit      (hit),
  .rejected (rejected)
);
